// ===== hw/rtl/escaped_frame_receive_deframer_defines.svh =====
// Assertion macros used by the deframer checker.
`ifndef ESCAPED_FRAME_RECEIVE_DEFRAMER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define EFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== hw/rtl/efd_pkg.sv =====
// Types and constants of the escaped frame receive deframer.
package efd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_GOT_ESC,
    PH_PACKET,
    PH_ESCD
  } phase_t;

  localparam logic [2:0] EV_PAYLOAD  = 3'd0;
  localparam logic [2:0] EV_COMPLETE = 3'd1;
  localparam logic [2:0] EV_FRAMING  = 3'd2;
  localparam logic [2:0] EV_TIMEOUT  = 3'd3;
  localparam logic [2:0] EV_DROP     = 3'd4;

  localparam logic [1:0] REG_ESCAPE_BYTE   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

  localparam logic [7:0]  ESCAPE_BYTE_RST   = 8'h7E;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd255;

  localparam logic [7:0] EXT_MARK = 8'hFF;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic [15:0] offset;
    logic [7:0]  ni_command;
    logic [15:0] msg_length;
    logic        extended;
    logic        last;
  } result_t;

  function automatic result_t mk_result(input logic [2:0] ev, input logic [7:0] d,
                                        input logic [15:0] off, input logic [7:0] cmd,
                                        input logic [15:0] len, input logic ext);
    result_t r;
    r.event_res  = ev;
    r.data       = d;
    r.offset     = off;
    r.ni_command = cmd;
    r.msg_length = len;
    r.extended   = ext;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/efd_channels.sv =====
// Channel interfaces of the escaped frame receive deframer.
interface efd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface efd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data;
  logic [15:0] offset;
  logic [7:0]  ni_command;
  logic [15:0] msg_length;
  logic        extended;
  logic        last;
  modport source (output valid, event_res, data, offset, ni_command, msg_length,
                  extended, last, input ready);
  modport sink (input valid, event_res, data, offset, ni_command, msg_length,
                extended, last, output ready);
endinterface

interface efd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/escaped_frame_receive_deframer.sv =====
// Receive deframer for a byte-stuffed, length-framed serial link. Each input
// beat is a received byte or a timer tick; the block hunts for escape + 0x00,
// unstuffs doubled escapes, parses a short or 0xFF-extended length header and
// the command byte, streams payload bytes with their offset and reports frame
// completion, oversize drop, framing errors and timeouts. An input beat is
// taken every clock while the four-entry result queue has room for two
// results; the results are written into the result queue. The output side
// delivers one result per clock while out_ch.ready is high; a beat that
// yields two (a bad frame start, or the final payload byte with completion)
// delivers them in turn. Configuration writes are always accepted.
module escaped_frame_receive_deframer (
  input  logic             clk,
  input  logic             rst,
  efd_in_if.sink           in_ch,
  efd_out_if.source        out_ch,
  efd_cfg_if.sink          cfg
);

  // configuration
  logic [7:0]  escape_byte;
  logic [15:0] timeout_ticks;
  logic [15:0] max_length;

  // frame state
  efd_pkg::phase_t phase, phase_next;
  logic        error_latched, error_latched_next;
  logic [16:0] received_count, received_count_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  length_high, length_high_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic        ext_frame, ext_frame_next;

  // result queue
  efd_pkg::result_t fifo_mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fifo_count;

  logic in_fire, out_fire;
  efd_pkg::result_t res_q [2];
  logic [1:0] n_res;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (fifo_count <= 3'd2);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte   <= efd_pkg::ESCAPE_BYTE_RST;
      timeout_ticks <= efd_pkg::TIMEOUT_TICKS_RST;
      max_length    <= efd_pkg::MAX_LENGTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        efd_pkg::REG_ESCAPE_BYTE:   escape_byte   <= cfg.wdata[7:0];
        efd_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg.wdata;
        efd_pkg::REG_MAX_LENGTH:    max_length    <= cfg.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [16:0] tick_sum;
    logic        do_data;
    logic [16:0] pos;
    logic [7:0]  dval;
    logic [16:0] first;
    logic [15:0] len;
    logic [2:0]  ev;

    phase_next          = phase;
    error_latched_next  = error_latched;
    received_count_next = received_count;
    frame_length_next   = frame_length;
    length_high_next    = length_high;
    command_byte_next   = command_byte;
    elapsed_ticks_next  = elapsed_ticks;
    ext_frame_next      = ext_frame;
    res_q[0] = '0;
    res_q[1] = '0;
    n_res    = 2'd0;
    b        = in_ch.rx_byte;
    tick_sum = {1'b0, elapsed_ticks} + 17'd1;
    do_data  = 1'b0;
    pos      = received_count;
    dval     = b;
    first    = 17'd2;
    len      = '0;
    ev       = efd_pkg::EV_COMPLETE;

    if (in_fire) begin
      if (in_ch.command) begin
        if (phase == efd_pkg::PH_PACKET || phase == efd_pkg::PH_ESCD) begin
          if (tick_sum > {1'b0, timeout_ticks}) begin
            res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_TIMEOUT, '0, '0, '0, '0, 1'b0);
            n_res = n_res + 2'd1;
            phase_next          = efd_pkg::PH_HUNT;
            received_count_next = '0;
            frame_length_next   = '0;
            error_latched_next  = 1'b0;
          end else begin
            elapsed_ticks_next = tick_sum[15:0];
          end
        end
      end else begin
        unique case (phase)
          efd_pkg::PH_HUNT: begin
            if (b == escape_byte) begin
              phase_next         = efd_pkg::PH_GOT_ESC;
              error_latched_next = 1'b0;
            end else if (!error_latched) begin
              res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_FRAMING, '0, '0, '0, '0, 1'b0);
              n_res = n_res + 2'd1;
              error_latched_next = 1'b1;
            end
          end
          efd_pkg::PH_GOT_ESC: begin
            if (b == 8'd0) begin
              phase_next          = efd_pkg::PH_PACKET;
              received_count_next = '0;
              elapsed_ticks_next  = '0;
            end else begin
              res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_FRAMING, '0, '0, '0, '0, 1'b0);
              n_res = n_res + 2'd1;
              // re-run the byte as a hunting byte; the latch is clear here
              if (b == escape_byte) begin
                phase_next         = efd_pkg::PH_GOT_ESC;
                error_latched_next = 1'b0;
              end else begin
                phase_next = efd_pkg::PH_HUNT;
                res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_FRAMING, '0, '0, '0, '0,
                                                     1'b0);
                n_res = n_res + 2'd1;
                error_latched_next = 1'b1;
              end
            end
          end
          efd_pkg::PH_PACKET: begin
            // store header bytes
            if (received_count == 17'd0) begin
              ext_frame_next    = (b == efd_pkg::EXT_MARK);
              frame_length_next = {8'd0, b};
            end else if (received_count == 17'd1) begin
              if (ext_frame) length_high_next = b;
              else command_byte_next = b;
            end else if (received_count == 17'd2 && ext_frame) begin
              frame_length_next = {length_high, b};
            end else if (received_count == 17'd3 && ext_frame) begin
              command_byte_next = b;
            end
            received_count_next = received_count + 17'd1;
            if (b == escape_byte) begin
              phase_next = efd_pkg::PH_ESCD;
            end else begin
              do_data = 1'b1;
              pos     = received_count;
              dval    = b;
            end
          end
          efd_pkg::PH_ESCD: begin
            phase_next = efd_pkg::PH_PACKET;
            if (b == escape_byte) begin
              do_data = 1'b1;
              pos     = received_count - 17'd1;
              dval    = escape_byte;
            end else begin
              res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_FRAMING, '0, '0, '0, '0, 1'b0);
              n_res = n_res + 2'd1;
              if (b == 8'd0) begin
                received_count_next = '0;
              end else begin
                phase_next          = efd_pkg::PH_HUNT;
                received_count_next = '0;
                frame_length_next   = '0;
                error_latched_next  = 1'b0;
              end
            end
          end
        endcase

        if (do_data) begin
          first = ext_frame_next ? 17'd4 : 17'd2;
          if (pos >= first) begin
            res_q[n_res[0]] = efd_pkg::mk_result(efd_pkg::EV_PAYLOAD, dval,
                                                 16'(pos - first), '0, '0, 1'b0);
            n_res = n_res + 2'd1;
          end
          // completion is not checked right after the first header byte, nor after the extended length's low byte
          if (!(received_count_next == 17'd1 ||
                (ext_frame_next && received_count_next == 17'd3)) &&
              received_count_next > {1'b0, frame_length_next}) begin
            len = frame_length_next - 16'd1;
            ev  = (len > max_length) ? efd_pkg::EV_DROP : efd_pkg::EV_COMPLETE;
            res_q[n_res[0]] = efd_pkg::mk_result(ev, '0, '0, command_byte_next, len,
                                                 ext_frame_next);
            n_res = n_res + 2'd1;
            phase_next          = efd_pkg::PH_HUNT;
            received_count_next = '0;
            frame_length_next   = '0;
            error_latched_next  = 1'b0;
          end
        end
      end
    end

    if (n_res == 2'd1) res_q[0].last = 1'b1;
    if (n_res == 2'd2) res_q[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= efd_pkg::PH_HUNT;
      error_latched  <= 1'b0;
      received_count <= '0;
      frame_length   <= '0;
      length_high    <= '0;
      command_byte   <= '0;
      elapsed_ticks  <= '0;
      ext_frame      <= 1'b0;
    end else begin
      phase          <= phase_next;
      error_latched  <= error_latched_next;
      received_count <= received_count_next;
      frame_length   <= frame_length_next;
      length_high    <= length_high_next;
      command_byte   <= command_byte_next;
      elapsed_ticks  <= elapsed_ticks_next;
      ext_frame      <= ext_frame_next;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + n_res;
      rd_ptr     <= rd_ptr + {1'b0, out_fire};
      fifo_count <= fifo_count + {1'b0, n_res} - {2'b00, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) fifo_mem[wr_ptr] <= res_q[0];
    if (n_res == 2'd2) fifo_mem[wr_ptr + 2'd1] <= res_q[1];
  end

  assign out_ch.valid      = (fifo_count != 3'd0);
  assign out_ch.event_res  = fifo_mem[rd_ptr].event_res;
  assign out_ch.data       = fifo_mem[rd_ptr].data;
  assign out_ch.offset     = fifo_mem[rd_ptr].offset;
  assign out_ch.ni_command = fifo_mem[rd_ptr].ni_command;
  assign out_ch.msg_length = fifo_mem[rd_ptr].msg_length;
  assign out_ch.extended   = fifo_mem[rd_ptr].extended;
  assign out_ch.last       = fifo_mem[rd_ptr].last;

endmodule

// ===== hw/rtl/efd_checker.sv =====
// Port-level checks of the escaped frame receive deframer, bound to its top level.
`include "escaped_frame_receive_deframer_defines.svh"

module efd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [7:0]  data,
  input logic [15:0] offset,
  input logic [7:0]  ni_command,
  input logic [15:0] msg_length,
  input logic        extended,
  input logic        last
);

  // hold a stalled result (all fields but ni_command and extended)
  `EFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(data) && $stable(offset) && $stable(msg_length) && $stable(last))

  // only payload beats carry data and offset
  `EFD_ASSERT_NOW(a_payload_fields, clk, rst, out_valid && event_res != efd_pkg::EV_PAYLOAD, data == 8'd0 && offset == 16'd0)

  // only completion and drop carry the frame summary
  `EFD_ASSERT_NOW(a_summary_fields, clk, rst, out_valid && event_res != efd_pkg::EV_COMPLETE && event_res != efd_pkg::EV_DROP, ni_command == 8'd0 && msg_length == 16'd0 && !extended)

  // completion, drop and timeout always close the beat's results
  `EFD_ASSERT_NOW(a_close_last, clk, rst, out_valid && (event_res == efd_pkg::EV_COMPLETE || event_res == efd_pkg::EV_DROP || event_res == efd_pkg::EV_TIMEOUT), last)

endmodule

bind escaped_frame_receive_deframer efd_checker u_efd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_res  (out_ch.event_res),
  .data       (out_ch.data),
  .offset     (out_ch.offset),
  .ni_command (out_ch.ni_command),
  .msg_length (out_ch.msg_length),
  .extended   (out_ch.extended),
  .last       (out_ch.last)
);
